// File: rtl/core/sd_card_init_sequencer_assert.svh
// assertion macros shared by the sd card init sequencer checker
// no dependencies; included by the checker file
`ifndef SD_CARD_INIT_SEQUENCER_ASSERT_SVH
`define SD_CARD_INIT_SEQUENCER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define SDI_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define SDI_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/sdi_pkg.sv
// types and constants of the sd card init sequencer
// no dependencies; used by sdi_fsm and sd_card_init_sequencer
package sdi_pkg;

    typedef enum logic [3:0] {
        PH_IDLE    = 4'd0,
        PH_CMD0    = 4'd1,
        PH_CMD8    = 4'd2,
        PH_APP41   = 4'd3,
        PH_ACMD41  = 4'd4,
        PH_CMD2    = 4'd5,
        PH_CMD3    = 4'd6,
        PH_CMD7    = 4'd7,
        PH_CMD16   = 4'd8,
        PH_APP6    = 4'd9,
        PH_ACMD6   = 4'd10,
        PH_OK      = 4'd11,
        PH_FAILCMD = 4'd12,
        PH_FAILIDL = 4'd13
    } phase_t;

    // request kind carried on s_tuser
    localparam logic REQ_START = 1'b0;
    localparam logic REQ_DONE  = 1'b1;

    localparam logic [1:0] OUTCOME_OK = 2'd0;

    localparam logic [1:0] KIND_SHORT = 2'd0;
    localparam logic [1:0] KIND_NONE  = 2'd1;
    localparam logic [1:0] KIND_LONG  = 2'd2;
    localparam logic [1:0] KIND_BUSY  = 2'd3;

    localparam logic [1:0] FAIL_NONE = 2'd0;
    localparam logic [1:0] FAIL_CMD  = 2'd1;
    localparam logic [1:0] FAIL_IDLE = 2'd2;

    localparam logic [5:0] SD_CMD0   = 6'd0;
    localparam logic [5:0] SD_CMD2   = 6'd2;
    localparam logic [5:0] SD_CMD3   = 6'd3;
    localparam logic [5:0] SD_ACMD6  = 6'd6;
    localparam logic [5:0] SD_CMD7   = 6'd7;
    localparam logic [5:0] SD_CMD8   = 6'd8;
    localparam logic [5:0] SD_CMD16  = 6'd16;
    localparam logic [5:0] SD_ACMD41 = 6'd41;
    localparam logic [5:0] SD_CMD55  = 6'd55;

    localparam logic [31:0] ARG_CMD8       = 32'h0000_01aa;
    localparam logic [31:0] ARG_ACMD41_HCS = 32'h40ff_8000;
    localparam logic [31:0] ARG_ACMD41_SC  = 32'h00ff_8000;
    localparam logic [31:0] ARG_BLKLEN     = 32'd512;
    localparam logic [31:0] ARG_BUS4       = 32'd2;

    localparam int unsigned OCR_BUSY_BIT = 31;
    localparam int unsigned OCR_CCS_BIT  = 30;

    localparam logic [9:0] RETRY_LIMIT_RST = 10'd1000;

    typedef struct packed {
        logic        issue;
        logic [5:0]  cmd_index;
        logic [31:0] cmd_argument;
        logic [1:0]  response_kind;
        logic        wait_first;
        logic        finished;
        logic        succeeded;
        logic        block_addressed;
        logic        four_bit_bus;
        logic [15:0] card_address;
        logic [1:0]  fail_cause;
    } result_t;

endpackage

// File: rtl/core/sdi_fsm.sv
// bring-up state machine: card state registers, next-command and report logic
// depends on sdi_pkg
module sdi_fsm (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             step_en,
    input  logic             command,
    input  logic [1:0]       outcome,
    input  logic [31:0]      response_word,
    input  logic [9:0]       retry_limit,
    output sdi_pkg::result_t res
);

    sdi_pkg::phase_t phase_reg, phase_next;
    logic [9:0]  retry_reg, retry_next;
    logic        v2_reg, v2_next;
    logic        hc_reg, hc_next;
    logic [15:0] rca_reg, rca_next;
    logic        wide_reg, wide_next;

    logic        ok;
    logic        ocr_ready;
    logic [9:0]  retry_inc;
    logic        idle_fail;

    assign ok        = (outcome == sdi_pkg::OUTCOME_OK);
    assign ocr_ready = response_word[sdi_pkg::OCR_BUSY_BIT];
    assign retry_inc = retry_reg + 10'd1;
    assign idle_fail = (retry_inc == 10'd0) || (retry_inc >= retry_limit);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= sdi_pkg::PH_IDLE;
            retry_reg <= '0;
            v2_reg    <= 1'b0;
            hc_reg    <= 1'b0;
            rca_reg   <= '0;
            wide_reg  <= 1'b0;
        end else if (step_en) begin
            phase_reg <= phase_next;
            retry_reg <= retry_next;
            v2_reg    <= v2_next;
            hc_reg    <= hc_next;
            rca_reg   <= rca_next;
            wide_reg  <= wide_next;
        end
    end

    // next state
    always_comb begin
        phase_next = phase_reg;
        retry_next = retry_reg;
        v2_next    = v2_reg;
        hc_next    = hc_reg;
        rca_next   = rca_reg;
        wide_next  = wide_reg;
        if (command == sdi_pkg::REQ_START) begin
            phase_next = sdi_pkg::PH_CMD0;
            retry_next = '0;
            v2_next    = 1'b0;
            hc_next    = 1'b0;
            rca_next   = '0;
            wide_next  = 1'b0;
        end else begin
            case (phase_reg)
                sdi_pkg::PH_CMD0: begin
                    phase_next = ok ? sdi_pkg::PH_CMD8 : sdi_pkg::PH_FAILCMD;
                end
                sdi_pkg::PH_CMD8: begin
                    // a failed cmd8 only means a version 1 card
                    v2_next    = ok;
                    retry_next = '0;
                    phase_next = sdi_pkg::PH_APP41;
                end
                sdi_pkg::PH_APP41: begin
                    phase_next = ok ? sdi_pkg::PH_ACMD41 : sdi_pkg::PH_FAILCMD;
                end
                sdi_pkg::PH_ACMD41: begin
                    if (!ok) begin
                        phase_next = sdi_pkg::PH_FAILCMD;
                    end else if (ocr_ready) begin
                        hc_next    = response_word[sdi_pkg::OCR_CCS_BIT];
                        phase_next = sdi_pkg::PH_CMD2;
                    end else begin
                        retry_next = retry_inc;
                        phase_next = idle_fail ? sdi_pkg::PH_FAILIDL : sdi_pkg::PH_APP41;
                    end
                end
                sdi_pkg::PH_CMD2: begin
                    phase_next = ok ? sdi_pkg::PH_CMD3 : sdi_pkg::PH_FAILCMD;
                end
                sdi_pkg::PH_CMD3: begin
                    if (ok) begin
                        rca_next   = response_word[31:16];
                        phase_next = sdi_pkg::PH_CMD7;
                    end else begin
                        phase_next = sdi_pkg::PH_FAILCMD;
                    end
                end
                sdi_pkg::PH_CMD7: begin
                    if (!ok) begin
                        phase_next = sdi_pkg::PH_FAILCMD;
                    end else begin
                        phase_next = hc_reg ? sdi_pkg::PH_APP6 : sdi_pkg::PH_CMD16;
                    end
                end
                sdi_pkg::PH_CMD16: begin
                    phase_next = ok ? sdi_pkg::PH_APP6 : sdi_pkg::PH_FAILCMD;
                end
                sdi_pkg::PH_APP6: begin
                    // width step failure falls back to a one-bit bus
                    if (!ok) begin
                        wide_next  = 1'b0;
                        phase_next = sdi_pkg::PH_OK;
                    end else begin
                        phase_next = sdi_pkg::PH_ACMD6;
                    end
                end
                sdi_pkg::PH_ACMD6: begin
                    wide_next  = ok;
                    phase_next = sdi_pkg::PH_OK;
                end
                default: begin
                end
            endcase
        end
    end

    // outputs
    always_comb begin
        res = '0;
        if (command == sdi_pkg::REQ_START) begin
            res.issue         = 1'b1;
            res.cmd_index     = sdi_pkg::SD_CMD0;
            res.response_kind = sdi_pkg::KIND_NONE;
        end else begin
            case (phase_reg)
                sdi_pkg::PH_CMD0: begin
                    if (ok) begin
                        res.issue        = 1'b1;
                        res.cmd_index    = sdi_pkg::SD_CMD8;
                        res.cmd_argument = sdi_pkg::ARG_CMD8;
                    end
                end
                sdi_pkg::PH_CMD8: begin
                    res.issue     = 1'b1;
                    res.cmd_index = sdi_pkg::SD_CMD55;
                end
                sdi_pkg::PH_APP41: begin
                    if (ok) begin
                        res.issue        = 1'b1;
                        res.cmd_index    = sdi_pkg::SD_ACMD41;
                        res.cmd_argument = v2_reg ? sdi_pkg::ARG_ACMD41_HCS
                                                  : sdi_pkg::ARG_ACMD41_SC;
                    end
                end
                sdi_pkg::PH_ACMD41: begin
                    if (ok && ocr_ready) begin
                        res.issue         = 1'b1;
                        res.cmd_index     = sdi_pkg::SD_CMD2;
                        res.response_kind = sdi_pkg::KIND_LONG;
                    end else if (ok && !idle_fail) begin
                        // card still busy: pause, then poll again
                        res.issue      = 1'b1;
                        res.cmd_index  = sdi_pkg::SD_CMD55;
                        res.wait_first = 1'b1;
                    end
                end
                sdi_pkg::PH_CMD2: begin
                    if (ok) begin
                        res.issue     = 1'b1;
                        res.cmd_index = sdi_pkg::SD_CMD3;
                    end
                end
                sdi_pkg::PH_CMD3: begin
                    if (ok) begin
                        res.issue         = 1'b1;
                        res.cmd_index     = sdi_pkg::SD_CMD7;
                        res.cmd_argument  = {response_word[31:16], 16'd0};
                        res.response_kind = sdi_pkg::KIND_BUSY;
                    end
                end
                sdi_pkg::PH_CMD7: begin
                    if (ok) begin
                        res.issue = 1'b1;
                        if (hc_reg) begin
                            res.cmd_index    = sdi_pkg::SD_CMD55;
                            res.cmd_argument = {rca_reg, 16'd0};
                        end else begin
                            res.cmd_index    = sdi_pkg::SD_CMD16;
                            res.cmd_argument = sdi_pkg::ARG_BLKLEN;
                        end
                    end
                end
                sdi_pkg::PH_CMD16: begin
                    if (ok) begin
                        res.issue        = 1'b1;
                        res.cmd_index    = sdi_pkg::SD_CMD55;
                        res.cmd_argument = {rca_reg, 16'd0};
                    end
                end
                sdi_pkg::PH_APP6: begin
                    if (ok) begin
                        res.issue        = 1'b1;
                        res.cmd_index    = sdi_pkg::SD_ACMD6;
                        res.cmd_argument = sdi_pkg::ARG_BUS4;
                    end
                end
                default: begin
                end
            endcase

            // final report follows the phase reached by this request
            case (phase_next)
                sdi_pkg::PH_OK: begin
                    res.finished        = 1'b1;
                    res.succeeded       = 1'b1;
                    res.block_addressed = hc_next;
                    res.four_bit_bus    = wide_next;
                    res.card_address    = rca_next;
                end
                sdi_pkg::PH_FAILCMD: begin
                    res.finished   = 1'b1;
                    res.fail_cause = sdi_pkg::FAIL_CMD;
                end
                sdi_pkg::PH_FAILIDL: begin
                    res.finished   = 1'b1;
                    res.fail_cause = sdi_pkg::FAIL_IDLE;
                end
                default: begin
                end
            endcase
        end
    end

endmodule

// File: rtl/core/sd_card_init_sequencer.sv
// sd card init sequencer: a request is held in the input register, then its result in the result register
// throughput one request per cycle unless the result stalls; the input register
// feeds the state machine and the result register in the same cycle, so a stalled
// result does not block the input stage until both registers are full
// reset (aresetn low, synchronous) returns to idle before start, retry limit 1000
// depends on sdi_pkg and sdi_fsm
module sd_card_init_sequencer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // outcome[1:0], response_word[33:2], zero pad[39:34]
    input  logic        s_tuser,   // command[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    // issue[0], cmd_index[6:1], cmd_argument[38:7], response_kind[40:39],
    // wait_first[41], finished[42], succeeded[43], block_addressed[44],
    // four_bit_bus[45], card_address[61:46], fail_cause[63:62]
    output logic [63:0] m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [9:0]  cfg_data
);

    logic        in_valid_reg;
    logic        in_cmd_reg;
    logic [1:0]  in_outcome_reg;
    logic [31:0] in_resp_reg;
    logic        out_valid_reg;
    logic [63:0] out_data_reg;
    logic [9:0]  retry_limit_reg;

    logic             advance;
    sdi_pkg::result_t res;

    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            retry_limit_reg <= sdi_pkg::RETRY_LIMIT_RST;
        end else if (cfg_valid) begin
            retry_limit_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_cmd_reg     <= s_tuser;
            in_outcome_reg <= s_tdata[1:0];
            in_resp_reg    <= s_tdata[33:2];
        end
    end

    sdi_fsm u_fsm (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .step_en       (advance),
        .command       (in_cmd_reg),
        .outcome       (in_outcome_reg),
        .response_word (in_resp_reg),
        .retry_limit   (retry_limit_reg),
        .res           (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= {res.fail_cause, res.card_address, res.four_bit_bus,
                             res.block_addressed, res.succeeded, res.finished,
                             res.wait_first, res.response_kind, res.cmd_argument,
                             res.cmd_index, res.issue};
        end
    end

    // s_tdata pad bits are unused
    logic unused_pad;
    assign unused_pad = ^s_tdata[39:34];

endmodule

// File: rtl/core/sdi_port_checker.sv
// port-level checks of the sd card init sequencer, bound to the top level
// depends on sd_card_init_sequencer_assert.svh
`include "sd_card_init_sequencer_assert.svh"

module sdi_port_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata
);

    // a stalled result holds
    `SDI_ASSERT_NXT(a_result_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result changed")

    // no command fields without an issue
    `SDI_ASSERT_IMP(a_no_issue_zero, aclk, aresetn, m_tvalid && !m_tdata[0], m_tdata[41:1] == 41'd0, "command fields set without issue")

    // report fields only once finished
    `SDI_ASSERT_IMP(a_report_gated, aclk, aresetn, m_tvalid && !m_tdata[42], m_tdata[63:43] == 21'd0, "report fields set before end")

    // success and failure cause exclude each other
    `SDI_ASSERT_IMP(a_end_cause, aclk, aresetn, m_tvalid && m_tdata[42], m_tdata[43] == (m_tdata[63:62] == 2'd0), "end report inconsistent")

endmodule

bind sd_card_init_sequencer sdi_port_checker u_sdi_port_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
